FILE: hdl/idh_pkg.sv
`default_nettype none
package idh_pkg;

  localparam int unsigned MAX_PREVIEW = 64;
  localparam int unsigned MAX_SOURCE  = 4096;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;

  localparam int unsigned NUM_W     = 20;
  localparam int unsigned DEN_W     = 14;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic        KIND_PIXEL = 1'b0;
  localparam logic        KIND_STATS = 1'b1;

  localparam logic [31:0] INVALID_ID    = 32'hFFFF_FFFF;
  localparam logic [23:0] INVALID_COLOR = 24'h141619;
  localparam logic [31:0] HASH_K0       = 32'h9e37_79b9;
  localparam logic [31:0] HASH_K1       = 32'h21f0_aaad;
  localparam logic [31:0] HASH_K2       = 32'h735a_2d97;
  localparam logic [7:0]  CHAN_MASK     = 8'hBF;
  localparam logic [7:0]  CHAN_BASE     = 8'd64;

  typedef enum logic [1:0] {
    SU_LOAD,
    SU_RUN,
    SU_DONE
  } setup_state_t;

  typedef struct packed {
    logic        ready;
    logic [12:0] w;
    logic [12:0] h;
    logic [6:0]  pc;
    logic [6:0]  pr;
    logic [12:0] col_q;
    logic [5:0]  col_rem;
    logic [12:0] row_q;
    logic [5:0]  row_rem;
  } geom_t;

  typedef struct packed {
    logic        has_pix;
    logic        has_stat;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] id;
    logic [31:0] min_id;
    logic [31:0] max_id;
    logic [24:0] inv;
    logic [6:0]  pw;
    logic [6:0]  ph;
  } job_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] col;
    logic [11:0] row;
    logic [31:0] id_res;
    logic [23:0] color;
    logic [31:0] min_id;
    logic [31:0] max_id;
    logic [24:0] invalid_count;
    logic [6:0]  pv_cols;
    logic [6:0]  pv_rows;
    logic        last;
  } res_t;

  function automatic logic [23:0] hash_color(input logic [31:0] h);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = CHAN_BASE + (h[7:0] & CHAN_MASK);
    g = CHAN_BASE + (h[15:8] & CHAN_MASK);
    b = CHAN_BASE + (h[23:16] & CHAN_MASK);
    return {r, g, b};
  endfunction

endpackage
`default_nettype wire

FILE: hdl/idh_fifo.sv
`default_nettype none
module idh_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire logic [WIDTH-1:0]             wdata,
  input  wire logic                         pop,
  output logic      [WIDTH-1:0]             rdata,
  output logic                              full,
  output logic                              empty,
  output logic      [$clog2(DEPTH+1)-1:0]   count
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [IW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/idh_setup.sv
`default_nettype none
module idh_setup
  import idh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output geom_t                      geom,
  output logic                       restart
);

  setup_state_t         state_r, state_nxt;
  logic [1:0]           step_r, step_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [12:0]          w_reg_r, h_reg_r;
  logic [12:0]          w_eff, h_eff, longer;
  logic                 fits_preview;
  logic [NUM_W-1:0]     quo_r, quo_nxt, num_load;
  logic [DEN_W-1:0]     rem_r, rem_nxt, den_r, den_load;
  logic [DEN_W:0]       shifted;
  logic                 ge;
  logic                 last_iter;
  logic [6:0]           pc_r, pr_r;
  logic [12:0]          col_q_r, row_q_r;
  logic [5:0]           col_rem_r, row_rem_r;
  logic [6:0]           side_q;

  assign restart = cfg_we & ((cfg_index == CFG_SOURCE_WIDTH) ||
                             (cfg_index == CFG_SOURCE_HEIGHT));

  always_comb begin
    if (w_reg_r == '0) begin
      w_eff = 13'd1;
    end else if (w_reg_r > 13'(MAX_SOURCE)) begin
      w_eff = 13'(MAX_SOURCE);
    end else begin
      w_eff = w_reg_r;
    end
    if (h_reg_r == '0) begin
      h_eff = 13'd1;
    end else if (h_reg_r > 13'(MAX_SOURCE)) begin
      h_eff = 13'(MAX_SOURCE);
    end else begin
      h_eff = h_reg_r;
    end
    longer       = (w_eff > h_eff) ? w_eff : h_eff;
    fits_preview = (longer <= 13'(MAX_PREVIEW));
  end

  // preview sides first, then the per-frame sampling steps
  always_comb begin
    case (step_r)
      2'd0: begin
        num_load = NUM_W'(w_eff) * NUM_W'(2 * MAX_PREVIEW) + NUM_W'(longer);
        den_load = {longer, 1'b0};
      end
      2'd1: begin
        num_load = NUM_W'(h_eff) * NUM_W'(2 * MAX_PREVIEW) + NUM_W'(longer);
        den_load = {longer, 1'b0};
      end
      2'd2: begin
        num_load = NUM_W'(w_eff);
        den_load = DEN_W'(pc_r);
      end
      default: begin
        num_load = NUM_W'(h_eff);
        den_load = DEN_W'(pr_r);
      end
    endcase
  end

  always_comb begin
    shifted   = {rem_r, quo_r[NUM_W-1]};
    ge        = (shifted >= {1'b0, den_r});
    rem_nxt   = ge ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
    quo_nxt   = {quo_r[NUM_W-2:0], ge};
    last_iter = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
    side_q    = (quo_nxt == '0) ? 7'd1 : 7'(quo_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      SU_LOAD: begin
        state_nxt = SU_RUN;
        cnt_nxt   = '0;
      end
      SU_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_iter) begin
          step_nxt  = step_r + 1'b1;
          state_nxt = (step_r == 2'd3) ? SU_DONE : SU_LOAD;
        end
      end
      SU_DONE: begin
        state_nxt = SU_DONE;
      end
      default: begin
        state_nxt = SU_LOAD;
      end
    endcase
    if (restart) begin
      state_nxt = SU_LOAD;
      step_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SU_LOAD;
      step_r  <= '0;
      cnt_r   <= '0;
      w_reg_r <= 13'd64;
      h_reg_r <= 13'd64;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we && cfg_index == CFG_SOURCE_WIDTH) begin
        w_reg_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_SOURCE_HEIGHT) begin
        h_reg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == SU_LOAD) begin
      quo_r <= num_load;
      rem_r <= '0;
      den_r <= den_load;
    end else if (state_r == SU_RUN) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      if (last_iter) begin
        case (step_r)
          2'd0: pc_r <= fits_preview ? 7'(w_eff) : side_q;
          2'd1: pr_r <= fits_preview ? 7'(h_eff) : side_q;
          2'd2: begin
            col_q_r   <= 13'(quo_nxt);
            col_rem_r <= 6'(rem_nxt);
          end
          default: begin
            row_q_r   <= 13'(quo_nxt);
            row_rem_r <= 6'(rem_nxt);
          end
        endcase
      end
    end
  end

  always_comb begin
    geom.ready   = (state_r == SU_DONE);
    geom.w       = w_eff;
    geom.h       = h_eff;
    geom.pc      = pc_r;
    geom.pr      = pr_r;
    geom.col_q   = col_q_r;
    geom.col_rem = col_rem_r;
    geom.row_q   = row_q_r;
    geom.row_rem = row_rem_r;
  end

endmodule
`default_nettype wire

FILE: hdl/idh_front.sv
`default_nettype none
module idh_front
  import idh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        restart,
  input  wire geom_t       geom,
  input  wire logic        accept,
  input  wire logic [31:0] in_id,
  output logic             job_push,
  output job_t             job
);

  logic [11:0] col_cnt_r, col_cnt_nxt;
  logic [11:0] row_cnt_r, row_cnt_nxt;
  logic [12:0] next_col_r, next_col_nxt;
  logic [5:0]  col_rem_r, col_rem_nxt;
  logic [12:0] next_row_r, next_row_nxt;
  logic [5:0]  row_rem_r, row_rem_nxt;
  logic        row_smp_r, row_smp_nxt;
  logic [31:0] min_r, min_nxt, min_upd;
  logic [31:0] max_r, max_nxt, max_upd;
  logic        any_r, any_nxt, any_upd;
  logic [24:0] inv_r, inv_nxt, inv_upd;

  logic        eor, eof, is_inv, sampled;
  logic [12:0] col_p1, row_p1;
  logic [6:0]  csum, rsum;
  logic        cwrap, rwrap;
  logic [12:0] next_col_adv, next_row_adv, next_row_sel;
  logic [5:0]  col_rem_adv, row_rem_adv, row_rem_sel;

  always_comb begin
    col_p1  = {1'b0, col_cnt_r} + 13'd1;
    row_p1  = {1'b0, row_cnt_r} + 13'd1;
    eor     = (col_p1 >= geom.w);
    eof     = eor & (row_p1 >= geom.h);
    is_inv  = (in_id == INVALID_ID);
    sampled = row_smp_r & ({1'b0, col_cnt_r} == next_col_r);

    // step to the next sampled column or row: quotient plus carried remainder
    csum         = {1'b0, col_rem_r} + {1'b0, geom.col_rem};
    cwrap        = (csum >= geom.pc);
    col_rem_adv  = cwrap ? 6'(csum - geom.pc) : csum[5:0];
    next_col_adv = next_col_r + geom.col_q + 13'(cwrap);

    rsum         = {1'b0, row_rem_r} + {1'b0, geom.row_rem};
    rwrap        = (rsum >= geom.pr);
    row_rem_adv  = rwrap ? 6'(rsum - geom.pr) : rsum[5:0];
    next_row_adv = next_row_r + geom.row_q + 13'(rwrap);
    next_row_sel = row_smp_r ? next_row_adv : next_row_r;
    row_rem_sel  = row_smp_r ? row_rem_adv : row_rem_r;

    min_upd = min_r;
    max_upd = max_r;
    any_upd = any_r;
    inv_upd = inv_r;
    if (is_inv) begin
      inv_upd = inv_r + 1'b1;
    end else begin
      any_upd = 1'b1;
      if (in_id < min_r) begin
        min_upd = in_id;
      end
      if (in_id > max_r) begin
        max_upd = in_id;
      end
    end
  end

  always_comb begin
    job.has_pix  = sampled;
    job.has_stat = eof;
    job.x        = col_cnt_r;
    job.y        = row_cnt_r;
    job.id       = in_id;
    job.min_id   = any_upd ? min_upd : '0;
    job.max_id   = any_upd ? max_upd : '0;
    job.inv      = inv_upd;
    job.pw       = geom.pc;
    job.ph       = geom.pr;
    job_push     = accept & (sampled | eof);
  end

  always_comb begin
    col_cnt_nxt  = col_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    next_col_nxt = next_col_r;
    col_rem_nxt  = col_rem_r;
    next_row_nxt = next_row_r;
    row_rem_nxt  = row_rem_r;
    row_smp_nxt  = row_smp_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    any_nxt      = any_r;
    inv_nxt      = inv_r;
    if (restart || (accept && eof)) begin
      col_cnt_nxt  = '0;
      row_cnt_nxt  = '0;
      next_col_nxt = '0;
      col_rem_nxt  = '0;
      next_row_nxt = '0;
      row_rem_nxt  = '0;
      row_smp_nxt  = 1'b1;
      min_nxt      = INVALID_ID;
      max_nxt      = '0;
      any_nxt      = 1'b0;
      inv_nxt      = '0;
    end else if (accept) begin
      min_nxt = min_upd;
      max_nxt = max_upd;
      any_nxt = any_upd;
      inv_nxt = inv_upd;
      if (eor) begin
        col_cnt_nxt  = '0;
        next_col_nxt = '0;
        col_rem_nxt  = '0;
        next_row_nxt = next_row_sel;
        row_rem_nxt  = row_rem_sel;
        row_cnt_nxt  = row_cnt_r + 1'b1;
        row_smp_nxt  = (row_p1 == next_row_sel);
      end else begin
        col_cnt_nxt = col_cnt_r + 1'b1;
        if (sampled) begin
          next_col_nxt = next_col_adv;
          col_rem_nxt  = col_rem_adv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      next_col_r <= '0;
      col_rem_r  <= '0;
      next_row_r <= '0;
      row_rem_r  <= '0;
      row_smp_r  <= 1'b1;
      min_r      <= INVALID_ID;
      max_r      <= '0;
      any_r      <= 1'b0;
      inv_r      <= '0;
    end else begin
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      next_col_r <= next_col_nxt;
      col_rem_r  <= col_rem_nxt;
      next_row_r <= next_row_nxt;
      row_rem_r  <= row_rem_nxt;
      row_smp_r  <= row_smp_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
      any_r      <= any_nxt;
      inv_r      <= inv_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/idh_back.sv
`default_nettype none
module idh_back
  import idh_pkg::*;
#(
  parameter int unsigned RES_DEPTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             job_empty,
  input  wire job_t                             job_head,
  output logic                                  job_pop,
  input  wire logic [$clog2(RES_DEPTH+1)-1:0]   res_count,
  output logic                                  res_push,
  output res_t                                  res_word
);

  localparam int unsigned CW = $clog2(RES_DEPTH + 1);

  logic          phase_r, phase_nxt;
  logic          va_r, vb_r;
  logic          pix_now, issue;
  logic [CW:0]   occ;
  res_t          word;
  logic [31:0]   ha, hb, hc, hd;
  logic [63:0]   p1, p2;
  res_t          res_a_r, res_b_r;
  logic [31:0]   m1_r, m2_r;
  logic          pix_a_r, pix_b_r, inv_a_r, inv_b_r;

  // room left in the result queue counts words still in the hash stages
  always_comb begin
    occ     = (CW+1)'(res_count) + (CW+1)'(va_r) + (CW+1)'(vb_r);
    pix_now = job_head.has_pix & ~phase_r;
    issue   = ~job_empty & (occ < (CW+1)'(RES_DEPTH));
    job_pop = issue & (~pix_now | ~job_head.has_stat);

    phase_nxt = phase_r;
    if (job_pop) begin
      phase_nxt = 1'b0;
    end else if (issue) begin
      phase_nxt = 1'b1;
    end

    word = '0;
    if (pix_now) begin
      word.kind   = KIND_PIXEL;
      word.col    = job_head.x;
      word.row    = job_head.y;
      word.id_res = job_head.id;
      word.last   = ~job_head.has_stat;
    end else begin
      word.kind          = KIND_STATS;
      word.min_id        = job_head.min_id;
      word.max_id        = job_head.max_id;
      word.invalid_count = job_head.inv;
      word.pv_cols       = job_head.pw;
      word.pv_rows       = job_head.ph;
      word.last          = 1'b1;
    end

    ha = job_head.id + HASH_K0;
    hb = ha ^ (ha >> 16);
    p1 = 64'(hb) * 64'(HASH_K1);
    hc = m1_r ^ (m1_r >> 15);
    p2 = 64'(hc) * 64'(HASH_K2);
    hd = m2_r ^ (m2_r >> 15);

    res_push = vb_r;
    res_word = res_b_r;
    if (!pix_b_r) begin
      res_word.color = '0;
    end else if (inv_b_r) begin
      res_word.color = INVALID_COLOR;
    end else begin
      res_word.color = hash_color(hd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      va_r    <= issue;
      vb_r    <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    res_a_r <= word;
    m1_r    <= p1[31:0];
    pix_a_r <= pix_now;
    inv_a_r <= (job_head.id == INVALID_ID);
    res_b_r <= res_a_r;
    m2_r    <= p2[31:0];
    pix_b_r <= pix_a_r;
    inv_b_r <= inv_a_r;
  end

endmodule
`default_nettype wire

FILE: hdl/id_preview_downscale_hash_color.sv
// a result reaches the output through the job queue, hash stages a and b and the
// result queue; a statistics word follows the pixel word of the same item
// one item per cycle while in_full is low; a backed-up result queue also raises in_full
// after reset and after each size register write, a setup pass runs four 20-step
// shift-subtract divisions (preview sides, then column and row steps), in_full high
// reset is synchronous, active low; both sizes return to 64 and a new frame starts
`default_nettype none
module id_preview_downscale_hash_color
  import idh_pkg::*;
#(
  parameter int unsigned JOB_DEPTH = 4,
  parameter int unsigned RES_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire logic [31:0]           in_id,
  output logic                       in_full,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic                       out_kind,
  output logic [11:0]                out_source_x,
  output logic [11:0]                out_source_y,
  output logic [31:0]                out_id_res,
  output logic [23:0]                out_color,
  output logic [31:0]                out_min_id,
  output logic [31:0]                out_max_id,
  output logic [24:0]                out_invalid_count,
  output logic [6:0]                 out_preview_width,
  output logic [6:0]                 out_preview_height,
  output logic                       out_last,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned JCW = $clog2(JOB_DEPTH + 1);

  geom_t                        geom;
  logic                         restart;
  logic                         accept;
  logic                         job_push, job_pop, job_full, job_empty;
  job_t                         job_in, job_head;
  logic                         res_push, res_full;
  res_t                         res_in, res_head;
  logic [$clog2(RES_DEPTH+1)-1:0] res_count;
  logic [JCW-1:0]               job_count;

  assign in_full = ~geom.ready | job_full;
  assign accept  = in_push & ~in_full;

  idh_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom),
    .restart   (restart)
  );

  idh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .geom     (geom),
    .accept   (accept),
    .in_id    (in_id),
    .job_push (job_push),
    .job      (job_in)
  );

  idh_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .pop   (job_pop),
    .rdata (job_head),
    .full  (job_full),
    .empty (job_empty),
    .count (job_count)
  );

  idh_back #(
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_word  (res_in)
  );

  idh_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .pop   (out_pop),
    .rdata (res_head),
    .full  (res_full),
    .empty (out_empty),
    .count (res_count)
  );

  assign out_kind           = res_head.kind;
  assign out_source_x       = res_head.col;
  assign out_source_y       = res_head.row;
  assign out_id_res         = res_head.id_res;
  assign out_color          = res_head.color;
  assign out_min_id         = res_head.min_id;
  assign out_max_id         = res_head.max_id;
  assign out_invalid_count  = res_head.invalid_count;
  assign out_preview_width  = res_head.pv_cols;
  assign out_preview_height = res_head.pv_rows;
  assign out_last           = res_head.last;

  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result word pushed into a full queue");

  a_job_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (!job_full && job_count < JCW'(JOB_DEPTH)))
    else $error("job pushed into a full queue");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> in_full)
    else $error("input open right after a size write");

  a_stats_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_in.kind == KIND_STATS) |-> res_in.last)
    else $error("statistics word without last");

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import idh_pkg::*;

  localparam int DRAIN = 8;
  localparam int RANDOM_IDS = 170;
  localparam int DIR_ROWS = 25;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam res_t NO_WORD = '0;
  localparam res_t INV_AT_ORIGIN = '{KIND_PIXEL, 12'd0, 12'd0, INVALID_ID, INVALID_COLOR,
                                     32'd0, 32'd0, 25'd0, 7'd0, 7'd0, 1'b1};
  localparam res_t INV_SECOND_COL = '{KIND_PIXEL, 12'd1, 12'd0, INVALID_ID, INVALID_COLOR,
                                      32'd0, 32'd0, 25'd0, 7'd0, 7'd0, 1'b1};
  localparam res_t INV_LAST_PIXEL = '{KIND_PIXEL, 12'd0, 12'd0, INVALID_ID, INVALID_COLOR,
                                      32'd0, 32'd0, 25'd0, 7'd0, 7'd0, 1'b0};
  localparam res_t ONE_INVALID_STATS = '{KIND_STATS, 12'd0, 12'd0, 32'd0, 24'd0,
                                         32'd0, 32'd0, 25'd1, 7'd1, 7'd1, 1'b1};

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [31:0]           id;
    logic [1:0]            n_typed;
    res_t                  t0;
    res_t                  t1;
  } dir_row_t;

  // typed rows: invalid ids only, where position and grey color are obvious
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     INVALID_ID,   2'd1, INV_AT_ORIGIN, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     32'h1,        2'd0, NO_WORD, NO_WORD},
    '{1'b1, CFG_SOURCE_WIDTH,  13'd0,     32'h0,        2'd0, NO_WORD, NO_WORD},
    '{1'b1, CFG_SOURCE_HEIGHT, 13'd0,     32'h0,        2'd0, NO_WORD, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     32'h0,        2'd0, NO_WORD, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     INVALID_ID,   2'd2, INV_LAST_PIXEL,
      ONE_INVALID_STATS},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     32'hFFFFFFFE, 2'd0, NO_WORD, NO_WORD},
    '{1'b1, CFG_SPARE_A,       13'h1FFF,  32'h0,        2'd0, NO_WORD, NO_WORD},
    '{1'b1, CFG_SPARE_B,       13'd0,     32'h0,        2'd0, NO_WORD, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     32'h55555555, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     32'hAAAAAAAA, 2'd0, NO_WORD, NO_WORD},
    '{1'b1, CFG_SOURCE_WIDTH,  13'h1FFF,  32'h0,        2'd0, NO_WORD, NO_WORD},
    '{1'b1, CFG_SOURCE_HEIGHT, 13'h1FFF,  32'h0,        2'd0, NO_WORD, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     INVALID_ID,   2'd1, INV_AT_ORIGIN, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     32'h1234,     2'd0, NO_WORD, NO_WORD},
    '{1'b1, CFG_SOURCE_WIDTH,  13'd3,     32'h0,        2'd0, NO_WORD, NO_WORD},
    '{1'b1, CFG_SOURCE_HEIGHT, 13'd2,     32'h0,        2'd0, NO_WORD, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     32'h7,        2'd0, NO_WORD, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     INVALID_ID,   2'd1, INV_SECOND_COL, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     32'h3,        2'd0, NO_WORD, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     32'h9,        2'd0, NO_WORD, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     INVALID_ID,   2'd0, NO_WORD, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     32'h1,        2'd0, NO_WORD, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     32'h80000000, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, CFG_SOURCE_WIDTH,  13'd0,     INVALID_ID,   2'd1, INV_SECOND_COL, NO_WORD}
  };

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic [31:0]           in_id = '0;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic                  out_kind;
  logic [11:0]           out_source_x;
  logic [11:0]           out_source_y;
  logic [31:0]           out_id_res;
  logic [23:0]           out_color;
  logic [31:0]           out_min_id;
  logic [31:0]           out_max_id;
  logic [24:0]           out_invalid_count;
  logic [6:0]            out_preview_width;
  logic [6:0]            out_preview_height;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int send_idle_pct = 16;
  int recv_idle_pct = 57;
  int mismatch_count = 0;
  int fed_total = 0;

  res_t awaited_preview[$];
  res_t step_words[$];

  // predictor state
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  int unsigned col_pos, row_pos, pcols, prows;
  int unsigned col_tap, col_frac, row_tap, row_frac;
  bit          row_hit, saw_valid;
  logic [31:0] id_lo, id_hi;
  logic [24:0] invalid_seen;

  id_preview_downscale_hash_color dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("id_preview_downscale_hash_color verification failed");
    $finish;
  end

  function automatic int unsigned clamp_side(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_SOURCE) return MAX_SOURCE;
    return v;
  endfunction

  function automatic int unsigned preview_len(input int unsigned side, input int unsigned longer);
    int unsigned p;
    if (longer <= MAX_PREVIEW) return side;
    p = (2 * side * MAX_PREVIEW + longer) / (2 * longer);
    return (p < 1) ? 1 : p;
  endfunction

  function automatic void restart_frame();
    int unsigned w, h, longer;
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    longer = (w > h) ? w : h;
    pcols = preview_len(w, longer);
    prows = preview_len(h, longer);
    col_pos = 0;
    row_pos = 0;
    col_tap = 0;
    col_frac = 0;
    row_tap = 0;
    row_frac = 0;
    row_hit = 1'b1;
    id_lo = INVALID_ID;
    id_hi = '0;
    saw_valid = 1'b0;
    invalid_seen = '0;
  endfunction

  function automatic void step_tap(inout int unsigned tap, inout int unsigned frac,
                                   input int unsigned size, input int unsigned prev);
    tap += size / prev;
    frac += size % prev;
    if (frac >= prev) begin
      frac -= prev;
      tap += 1;
    end
  endfunction

  function automatic logic [23:0] id_color(input logic [31:0] id);
    logic [31:0] h;
    logic [7:0]  r, g, b;
    if (id == INVALID_ID) return INVALID_COLOR;
    h = id + HASH_K0;
    h = (h ^ (h >> 16)) * HASH_K1;
    h = (h ^ (h >> 15)) * HASH_K2;
    h = h ^ (h >> 15);
    r = CHAN_BASE + (h[7:0] & CHAN_MASK);
    g = CHAN_BASE + (h[15:8] & CHAN_MASK);
    b = CHAN_BASE + (h[23:16] & CHAN_MASK);
    return {r, g, b};
  endfunction

  function automatic void apply_size_reg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SOURCE_WIDTH: width_reg = val;
      CFG_SOURCE_HEIGHT: height_reg = val;
      default: return;
    endcase
    restart_frame();
  endfunction

  // words caused by one source pixel land in step_words
  function automatic void predict_id(input logic [31:0] id);
    int unsigned w, h;
    bit          row_end, frame_end;
    res_t        r;
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    row_end = (col_pos + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);
    step_words.delete();
    if (id == INVALID_ID) begin
      invalid_seen = invalid_seen + 1'b1;
    end else begin
      saw_valid = 1'b1;
      if (id < id_lo) id_lo = id;
      if (id > id_hi) id_hi = id;
    end
    if (row_hit && col_pos == col_tap) begin
      r = '0;
      r.kind = KIND_PIXEL;
      r.col = 12'(col_pos);
      r.row = 12'(row_pos);
      r.id_res = id;
      r.color = id_color(id);
      r.last = !frame_end;
      step_words.insert(step_words.size(), r);
      step_tap(col_tap, col_frac, w, pcols);
    end
    if (frame_end) begin
      r = '0;
      r.kind = KIND_STATS;
      r.min_id = saw_valid ? id_lo : 32'd0;
      r.max_id = saw_valid ? id_hi : 32'd0;
      r.invalid_count = invalid_seen;
      r.pv_cols = 7'(pcols);
      r.pv_rows = 7'(prows);
      r.last = 1'b1;
      step_words.insert(step_words.size(), r);
      restart_frame();
      return;
    end
    if (row_end) begin
      col_pos = 0;
      col_tap = 0;
      col_frac = 0;
      if (row_hit) step_tap(row_tap, row_frac, h, prows);
      row_pos++;
      row_hit = (row_pos == row_tap);
    end else begin
      col_pos++;
    end
  endfunction

  function automatic logic [31:0] pick_id();
    case ($urandom_range(7))
      0: return INVALID_ID;
      1: return 32'($urandom_range(15));
      2: return $urandom_range(1) ? 32'hFFFF_FFFE : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic feed_id(input logic [31:0] id, input logic [1:0] n_typed,
                         input res_t t0, input res_t t1);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_id <= id;
    do @(posedge clk); while (in_full);
    predict_id(id);
    if (n_typed == 0) begin
      foreach (step_words[k]) awaited_preview.insert(awaited_preview.size(), step_words[k]);
    end else begin
      awaited_preview.insert(awaited_preview.size(), t0);
      if (n_typed == 2) awaited_preview.insert(awaited_preview.size(), t1);
    end
    fed_total++;
  endtask

  // size writes only once the block has drained and finished its setup pass
  task automatic set_size_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    in_push <= 1'b0;
    while (awaited_preview.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    while (in_full) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_size_reg(idx, val);
  endtask

  task automatic size_and_stream(input logic [12:0] w, input logic [12:0] h, input bit ragged);
    int unsigned span, frames, cut;
    set_size_reg(CFG_SOURCE_WIDTH, w);
    set_size_reg(CFG_SOURCE_HEIGHT, h);
    span = clamp_side(w) * clamp_side(h);
    frames = (ragged && span <= 64) ? $urandom_range(1, 3) : 1;
    repeat (frames) begin
      cut = span;
      if (ragged && span > 1 && $urandom_range(7) == 0) cut = $urandom_range(1, span - 1);
      repeat (cut) feed_id(pick_id(), 2'd0, NO_WORD, NO_WORD);
      if (cut < span) break;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_preview.size() == 0) begin
        $display("%0t: unexpected word, expected none actual kind %0d id %h", $time,
                 out_kind, out_id_res);
        mismatch_count++;
      end else begin
        want = awaited_preview.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("x", want.col, out_source_x);
        check_field("y", want.row, out_source_y);
        check_field("id_res", want.id_res, out_id_res);
        check_field("color", want.color, out_color);
        check_field("min_id", want.min_id, out_min_id);
        check_field("max_id", want.max_id, out_max_id);
        check_field("invalid_count", want.invalid_count, out_invalid_count);
        check_field("cols", want.pv_cols, out_preview_width);
        check_field("rows", want.pv_rows, out_preview_height);
        check_field("last", want.last, out_last);
      end
    end
  end

  initial begin
    int          base;
    logic [12:0] w, h;
    logic [12:0] big_w[3] = '{13'h1FFF, 13'd1, 13'd128};
    logic [12:0] big_h[3] = '{13'd1, 13'd4096, 13'd1};
    int          big_cut[3] = '{66, 66, 128};
    width_reg = 13'd64;
    height_reg = 13'd64;
    restart_frame();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIR_ROWS; k++) begin
      if (DIR_TAB[k].is_cfg) begin
        set_size_reg(DIR_TAB[k].idx, DIR_TAB[k].val);
      end else begin
        feed_id(DIR_TAB[k].id, DIR_TAB[k].n_typed, DIR_TAB[k].t0, DIR_TAB[k].t1);
      end
    end

    base = fed_total;
    while (fed_total - base < RANDOM_IDS) begin
      if (fed_total - base < RANDOM_IDS / 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 57;
      end else if (fed_total - base < 2 * RANDOM_IDS / 3) begin
        send_idle_pct = 57;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(9))
        0, 1: begin
          w = 13'($urandom_range(65, 100));
          h = 13'($urandom_range(0, 2));
          if ($urandom_range(1)) {w, h} = {h, w};
        end
        2: begin
          w = 13'($urandom_range(9, 16));
          h = 13'($urandom_range(9, 16));
        end
        default: begin
          w = 13'($urandom_range(0, 8));
          h = 13'($urandom_range(0, 8));
        end
      endcase
      if ($urandom_range(5) == 0) begin
        set_size_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, 13'($urandom));
      end
      size_and_stream(w, h, 1'b1);
    end

    // start of the widest and tallest frames, then a full rounding tie, no idling
    for (int k = 0; k < 3; k++) begin
      set_size_reg(CFG_SOURCE_WIDTH, big_w[k]);
      set_size_reg(CFG_SOURCE_HEIGHT, big_h[k]);
      repeat (big_cut[k]) feed_id(pick_id(), 2'd0, NO_WORD, NO_WORD);
    end

    in_push <= 1'b0;
    while (awaited_preview.size() != 0) @(posedge clk);
    repeat (4 * DRAIN) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("id_preview_downscale_hash_color verification clean");
    end else begin
      $display("id_preview_downscale_hash_color verification failed");
    end
    $finish;
  end

endmodule
